// ----- rtl/bfra_pkg.sv -----
// Shared types and constants for the best-fit record allocator.
package bfra_pkg;

  localparam int ID_COUNT_DEF    = 256;
  localparam int FREE_SLOTS_DEF  = 32;
  localparam int STORE_BYTES_DEF = 1048576;
  localparam logic [12:0] RECORD_EXTRA = 13'd5;

  localparam logic FUNC_INSERT  = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [1:0] ST_PLACE  = 2'd0;
  localparam logic [1:0] ST_APPEND = 2'd1;
  localparam logic [1:0] ST_REL    = 2'd2;
  localparam logic [1:0] ST_ERR    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_IDRD, S_CHECK, S_MERGE_A, S_MERGE_B, S_REL_END, S_FIT, S_FIT_END, S_RESULT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_CHECK, OP_SCAN_A, OP_SCAN_B, OP_REL_END, OP_FIT, OP_FIT_END,
    OP_LOAD
  } op_t;

  typedef struct packed {
    op_t  op;
    logic scan_start;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic oob;
    logic hit;
    logic is_rel;
    logic out_busy;
  } stat_t;

  typedef struct packed {
    logic [20:0] loc;
    logic [20:0] len;
  } free_ent_t;

  typedef struct packed {
    logic [20:0] loc;
    logic [12:0] len;
  } id_ent_t;

endpackage

// ----- rtl/bfra_if.sv -----
// Valid/ready channel interfaces for input and result beats.
interface bfra_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  rec_id;
  logic [11:0] name_length;
  modport source (output valid, func, rec_id, name_length, input ready);
  modport sink (input valid, func, rec_id, name_length, output ready);
endinterface

interface bfra_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] location;
  logic [1:0]  status;
  modport source (output valid, location, status, input ready);
  modport sink (input valid, location, status, output ready);
endinterface

// ----- rtl/bfra_ctrl.sv -----
// Sequencer: steps an item through id lookup, merge scans, fit scan and result.
module bfra_ctrl
  import bfra_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  stat_t stat,
  output logic  in_ready,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_IDRD;
      S_IDRD:    state_next = S_CHECK;
      S_CHECK: begin
        if (stat.oob) state_next = S_RESULT;
        else if (stat.hit) state_next = S_MERGE_A;
        else if (stat.is_rel) state_next = S_RESULT;
        else state_next = S_FIT;
      end
      S_MERGE_A: if (stat.last) state_next = S_MERGE_B;
      S_MERGE_B: if (stat.last) state_next = S_REL_END;
      S_REL_END: state_next = stat.is_rel ? S_RESULT : S_FIT;
      S_FIT:     if (stat.last) state_next = S_FIT_END;
      S_FIT_END: state_next = S_RESULT;
      S_RESULT:  if (!stat.out_busy) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op = OP_NONE;
    cmd.scan_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_CAPTURE;
      end
      S_IDRD: cmd.op = OP_NONE;
      S_CHECK: begin
        cmd.op = OP_CHECK;
        cmd.scan_start = 1'b1;
      end
      S_MERGE_A: begin
        cmd.op = OP_SCAN_A;
        cmd.scan_start = stat.last;
      end
      S_MERGE_B: cmd.op = OP_SCAN_B;
      S_REL_END: begin
        cmd.op = OP_REL_END;
        cmd.scan_start = 1'b1;
      end
      S_FIT:     cmd.op = OP_FIT;
      S_FIT_END: cmd.op = OP_FIT_END;
      S_RESULT:  if (!stat.out_busy) cmd.op = OP_LOAD;
      default:   cmd.op = OP_NONE;
    endcase
  end

endmodule

// ----- rtl/bfra_dp.sv -----
// Datapath: id and free tables, scan unit, end pointer and result register.
module bfra_dp
  import bfra_pkg::*;
#(
  parameter int ID_COUNT    = ID_COUNT_DEF,
  parameter int FREE_SLOTS  = FREE_SLOTS_DEF,
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        in_func,
  input  logic [7:0]  in_rec_id,
  input  logic [11:0] in_name_length,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [19:0] location,
  output logic [1:0]  status,
  output stat_t       stat
);

  localparam int IDW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
  localparam int FW  = $clog2(FREE_SLOTS);
  localparam int CW  = FW + 1;

  logic        func_r;
  logic [7:0]  id_r;
  logic [11:0] len_r;
  logic [12:0] size;
  logic [11:0] id_ext;
  logic [IDW-1:0] idx;

  id_ent_t   id_mem [ID_COUNT];
  id_ent_t   id_q;
  logic [ID_COUNT-1:0] id_valid;

  free_ent_t fmem [FREE_SLOTS];
  free_ent_t fq;
  logic [FREE_SLOTS-1:0] fvalid;

  logic [CW-1:0] cnt;
  logic [FW-1:0] pidx;
  logic          pend;

  logic [20:0] start;
  logic [21:0] stop;
  logic [20:0] ep;
  logic        emp_found;
  logic [FW-1:0] emp_idx;
  logic        best_found;
  logic [FW-1:0] best_idx;
  logic [20:0] best_len;
  logic [20:0] best_loc;
  logic [20:0] res_loc;
  logic [1:0]  res_status;

  logic scanning, match_a, match_b, fit_ok, stop_at_end, append_ok;

  assign size    = {1'b0, len_r} + RECORD_EXTRA;
  assign id_ext  = {4'b0, id_r};
  assign idx     = id_ext[IDW-1:0];
  assign scanning = (cmd.op == OP_SCAN_A) || (cmd.op == OP_SCAN_B) || (cmd.op == OP_FIT);

  assign match_a = pend && fvalid[pidx] &&
                   (({1'b0, fq.loc} + {1'b0, fq.len}) == {1'b0, start});
  assign match_b = pend && fvalid[pidx] && ({1'b0, fq.loc} == stop);
  assign fit_ok  = pend && fvalid[pidx] && (fq.len >= {8'b0, size}) &&
                   (!best_found || fq.len < best_len);
  assign stop_at_end = (stop == {1'b0, ep});
  assign append_ok = ({4'b0, ep} + {12'b0, size}) <= 25'(STORE_BYTES);

  assign stat.last     = pend && (pidx == FW'(FREE_SLOTS - 1));
  assign stat.oob      = {1'b0, id_ext} >= 13'(ID_COUNT);
  assign stat.hit      = id_valid[idx];
  assign stat.is_rel   = (func_r == FUNC_RELEASE);
  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    id_q <= id_mem[idx];
    if (cmd.op == OP_FIT_END && (best_found || append_ok)) begin
      id_mem[idx] <= '{loc: best_found ? best_loc : ep, len: size};
    end
  end

  always_ff @(posedge clk) begin
    fq <= fmem[cnt[FW-1:0]];
    if (cmd.op == OP_REL_END && !stop_at_end && emp_found) begin
      fmem[emp_idx] <= '{loc: start, len: 21'(stop - {1'b0, start})};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) begin
      func_r <= in_func;
      id_r   <= in_rec_id;
      len_r  <= in_name_length;
    end
    if (cmd.op == OP_CHECK) begin
      start <= id_q.loc;
      stop  <= {1'b0, id_q.loc} + {9'b0, id_q.len};
      res_loc <= '0;
      res_status <= stat.oob ? ST_ERR : ST_REL;
    end
    if (cmd.scan_start) begin
      emp_found  <= 1'b0;
      best_found <= 1'b0;
    end
    if (cmd.op == OP_SCAN_A && match_a) start <= fq.loc;
    if (cmd.op == OP_SCAN_B) begin
      if (match_b) stop <= {1'b0, fq.loc} + {1'b0, fq.len};
      if (pend && !emp_found && (!fvalid[pidx] || match_b)) begin
        emp_found <= 1'b1;
        emp_idx   <= pidx;
      end
    end
    if (cmd.op == OP_REL_END) begin
      res_loc <= '0;
      res_status <= ST_REL;
    end
    if (cmd.op == OP_FIT && fit_ok) begin
      best_found <= 1'b1;
      best_idx   <= pidx;
      best_len   <= fq.len;
      best_loc   <= fq.loc;
    end
    if (cmd.op == OP_FIT_END) begin
      if (best_found) begin
        res_loc <= best_loc;
        res_status <= ST_PLACE;
      end else if (append_ok) begin
        res_loc <= ep;
        res_status <= ST_APPEND;
      end else begin
        res_loc <= '0;
        res_status <= ST_ERR;
      end
    end
    if (cmd.op == OP_LOAD) begin
      location <= res_loc[19:0];
      status   <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      pend <= 1'b0;
      pidx <= '0;
    end else if (cmd.scan_start) begin
      cnt  <= '0;
      pend <= 1'b0;
    end else if (scanning) begin
      pend <= (cnt < CW'(FREE_SLOTS));
      pidx <= cnt[FW-1:0];
      if (cnt < CW'(FREE_SLOTS)) cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid    <= '0;
      id_valid  <= '0;
      ep        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CHECK && !stat.oob && stat.hit) id_valid[idx] <= 1'b0;
      if (cmd.op == OP_SCAN_A && match_a) fvalid[pidx] <= 1'b0;
      if (cmd.op == OP_SCAN_B && match_b) fvalid[pidx] <= 1'b0;
      if (cmd.op == OP_REL_END) begin
        if (stop_at_end) ep <= start;
        else if (emp_found) fvalid[emp_idx] <= 1'b1;
      end
      if (cmd.op == OP_FIT_END) begin
        if (best_found) begin
          fvalid[best_idx] <= 1'b0;
          id_valid[idx] <= 1'b1;
        end else if (append_ok) begin
          ep <= 21'({1'b0, ep} + {9'b0, size});
          id_valid[idx] <= 1'b1;
        end
      end
      if (cmd.op == OP_LOAD) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/best_fit_record_allocator_top.sv -----
// Top level of the best-fit record allocator.
// One item at a time; each free-table scan visits every slot of the free table.
// Release of a held id runs both merge scans; insert over a held id runs them and the fit scan.
// Insert of a fresh id runs the fit scan alone; a bad id or an empty release skips every scan.
// Rate is set by the one-slot-per-cycle scan over the free table read port.
// Synchronous reset empties both tables and zeroes the end pointer.
module best_fit_record_allocator_top
  import bfra_pkg::*;
#(
  parameter int ID_COUNT    = ID_COUNT_DEF,
  parameter int FREE_SLOTS  = FREE_SLOTS_DEF,
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input logic       clk,
  input logic       rst,
  bfra_in_if.sink   in_ch,
  bfra_out_if.source out_ch
);

  cmd_t  cmd;
  stat_t stat;

  bfra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .in_ready (in_ch.ready),
    .cmd      (cmd)
  );

  bfra_dp #(
    .ID_COUNT    (ID_COUNT),
    .FREE_SLOTS  (FREE_SLOTS),
    .STORE_BYTES (STORE_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .in_func        (in_ch.func),
    .in_rec_id      (in_ch.rec_id),
    .in_name_length (in_ch.name_length),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .location       (out_ch.location),
    .status         (out_ch.status),
    .stat           (stat)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while an item is in flight");

  a_loc_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != ST_PLACE && out_ch.status != ST_APPEND
      |-> out_ch.location == 20'd0)
    else $error("nonzero location on a release or error beat");
`endif

endmodule

// ----- verif/bfra_checker.sv -----
// Checker for the best-fit record allocator: predicts each result beat and compares it.
`timescale 1ns / 1ps
module bfra_checker
  import bfra_pkg::*;
#(
  parameter int ID_COUNT    = ID_COUNT_DEF,
  parameter int FREE_SLOTS  = FREE_SLOTS_DEF,
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  bfra_in_if   in_mon,
  bfra_out_if  out_mon,
  output int   fails,
  output int   pending,
  output int   n_placed,
  output int   n_appended,
  output int   n_released,
  output int   n_errors
);

  typedef struct {
    logic [19:0] location;
    logic [1:0]  status;
  } alloc_res_t;

  alloc_res_t  want_q[$];
  int unsigned end_ptr;
  int unsigned fr_loc [FREE_SLOTS];
  int unsigned fr_len [FREE_SLOTS];
  bit          fr_vld [FREE_SLOTS];
  int unsigned rec_loc[ID_COUNT];
  int unsigned rec_len[ID_COUNT];
  bit          rec_vld[ID_COUNT];

  function automatic void clear_model();
    end_ptr = 0;
    for (int i = 0; i < FREE_SLOTS; i++) begin
      fr_vld[i] = 0;
      fr_loc[i] = 0;
      fr_len[i] = 0;
    end
    for (int i = 0; i < ID_COUNT; i++) rec_vld[i] = 0;
  endfunction

  function automatic void return_range(int unsigned loc, int unsigned len);
    int unsigned start;
    int unsigned stop;
    int          slot;
    start = loc;
    stop  = loc + len;
    slot  = -1;
    for (int i = 0; i < FREE_SLOTS; i++) begin
      if (fr_vld[i] && fr_loc[i] + fr_len[i] == start) begin
        start = fr_loc[i];
        fr_vld[i] = 0;
      end
    end
    for (int i = 0; i < FREE_SLOTS; i++) begin
      if (fr_vld[i] && fr_loc[i] == stop) begin
        stop = fr_loc[i] + fr_len[i];
        fr_vld[i] = 0;
      end
    end
    if (stop == end_ptr) begin
      end_ptr = start & 32'h1FFFFF;
      return;
    end
    for (int i = 0; i < FREE_SLOTS; i++) begin
      if (!fr_vld[i]) begin
        slot = i;
        break;
      end
    end
    if (slot >= 0) begin
      fr_loc[slot] = start & 32'h1FFFFF;
      fr_len[slot] = (stop - start) & 32'h1FFFFF;
      fr_vld[slot] = 1;
    end
  endfunction

  function automatic void drop_record(int unsigned id);
    if (rec_vld[id]) begin
      rec_vld[id] = 0;
      return_range(rec_loc[id], rec_len[id]);
    end
  endfunction

  function automatic alloc_res_t allocate(logic func, logic [7:0] id, logic [11:0] nlen);
    alloc_res_t  r;
    int unsigned need;
    int          best;
    r.location = '0;
    best = -1;
    if (int'(id) >= ID_COUNT) begin
      r.status = ST_ERR;
      return r;
    end
    drop_record(id);
    if (func == FUNC_RELEASE) begin
      r.status = ST_REL;
      return r;
    end
    need = nlen + RECORD_EXTRA;
    for (int i = 0; i < FREE_SLOTS; i++) begin
      if (fr_vld[i] && fr_len[i] >= need && (best < 0 || fr_len[i] < fr_len[best]))
        best = i;
    end
    if (best >= 0) begin
      r.location = fr_loc[best][19:0];
      fr_vld[best] = 0;
      r.status = ST_PLACE;
      rec_loc[id] = fr_loc[best];
    end else if (longint'(end_ptr) + need <= STORE_BYTES) begin
      r.location = end_ptr[19:0];
      rec_loc[id] = end_ptr;
      end_ptr = (end_ptr + need) & 32'h1FFFFF;
      r.status = ST_APPEND;
    end else begin
      r.status = ST_ERR;
      return r;
    end
    rec_len[id] = need & 32'h1FFF;
    rec_vld[id] = 1;
    return r;
  endfunction

  assign pending = want_q.size();

  always @(posedge clk) begin
    alloc_res_t w;
    alloc_res_t p;
    if (rst) begin
      clear_model();
      want_q.delete();
      fails <= 0;
      n_placed <= 0;
      n_appended <= 0;
      n_released <= 0;
      n_errors <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        p = allocate(in_mon.func, in_mon.rec_id, in_mon.name_length);
        want_q.insert(want_q.size(), p);
      end
      if (out_mon.valid && out_mon.ready) begin
        case (out_mon.status)
          ST_PLACE:  n_placed <= n_placed + 1;
          ST_APPEND: n_appended <= n_appended + 1;
          ST_REL:    n_released <= n_released + 1;
          default:   n_errors <= n_errors + 1;
        endcase
        if (want_q.size() == 0) begin
          $error("unexpected result beat: location %0d status %0d",
                 out_mon.location, out_mon.status);
          fails <= fails + 1;
        end else begin
          w = want_q.pop_front();
          if (out_mon.location !== w.location || out_mon.status !== w.status) begin
            if (out_mon.location !== w.location)
              $error("location: expected %0d, got %0d", w.location, out_mon.location);
            if (out_mon.status !== w.status)
              $error("status: expected %0d, got %0d", w.status, out_mon.status);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

// ----- verif/best_fit_record_allocator_top_tb.sv -----
// Testbench top for the best-fit record allocator: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module best_fit_record_allocator_top_tb;
  import bfra_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   tx_idle = 0;
  int   rx_idle = 0;
  logic hold_go = 1'b0;
  int   hold_left;
  int   sent = 0;
  int   fails, pending, n_placed, n_appended, n_released, n_errors;

  bfra_in_if  in_ch();
  bfra_out_if out_ch();

  always #6 clk = ~clk;

  best_fit_record_allocator_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bfra_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fails      (fails),
    .pending    (pending),
    .n_placed   (n_placed),
    .n_appended (n_appended),
    .n_released (n_released),
    .n_errors   (n_errors)
  );

  // receiver flow control, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_go) begin
      hold_left <= 400;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  task automatic send(logic func, logic [7:0] id, logic [11:0] nlen);
    if ($urandom_range(0, 99) < tx_idle) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= func;
    in_ch.rec_id <= id;
    in_ch.name_length <= nlen;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_random(int id_pool);
    logic [11:0] nlen;
    nlen = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, 80));
    if ($urandom_range(0, 99) < 40)
      send(FUNC_RELEASE, 8'($urandom_range(0, id_pool)), 12'($urandom));
    else
      send(FUNC_INSERT, 8'($urandom_range(0, id_pool)), nlen);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_INSERT;
    in_ch.rec_id = '0;
    in_ch.name_length = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, append, hole reuse, merges, end pointer drop, empty release
    send(FUNC_INSERT, 8'd0, 12'd0);
    send(FUNC_INSERT, 8'd255, 12'hFFF);
    send(FUNC_INSERT, 8'd1, 12'd10);
    send(FUNC_RELEASE, 8'd1, 12'hFFF);
    send(FUNC_RELEASE, 8'd7, 12'd0);
    send(FUNC_INSERT, 8'd0, 12'd3);
    for (int i = 2; i < 7; i++) send(FUNC_INSERT, 8'(i), 12'd20);
    send(FUNC_RELEASE, 8'd3, 12'd0);
    send(FUNC_INSERT, 8'd8, 12'd10);
    send(FUNC_RELEASE, 8'd2, 12'd0);
    send(FUNC_RELEASE, 8'd4, 12'd0);
    send(FUNC_RELEASE, 8'd8, 12'd0);
    send(FUNC_RELEASE, 8'd6, 12'd0);
    send(FUNC_INSERT, 8'd5, 12'd30);
    send(FUNC_RELEASE, 8'd255, 12'd0);
    send(FUNC_RELEASE, 8'd0, 12'd0);
    send(FUNC_RELEASE, 8'd5, 12'd0);

    tx_idle = 28;
    rx_idle = 72;
    for (int i = 0; i < 60; i++) send_random(31);
    // many holes overflow the free table
    for (int i = 40; i < 110; i++) send(FUNC_INSERT, 8'(i), 12'($urandom_range(0, 40)));
    for (int i = 40; i < 110; i += 2) send(FUNC_RELEASE, 8'(i), 12'd0);

    tx_idle = 72;
    rx_idle = 28;
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    for (int i = 0; i < 60; i++) send_random(255);

    tx_idle = 0;
    rx_idle = 0;
    // large records until the store runs out
    for (int i = 0; i < 256; i++) send(FUNC_INSERT, 8'(i), 12'($urandom_range(3900, 4095)));
    for (int i = 0; i < 20; i++) send_random(255);
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("%0d input beats; results: %0d placed, %0d appended, %0d released, %0d errors",
             sent, n_placed, n_appended, n_released, n_errors);
    if (fails == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bfra_pkg.sv
rtl/bfra_if.sv
rtl/bfra_ctrl.sv
rtl/bfra_dp.sv
rtl/best_fit_record_allocator_top.sv
verif/bfra_checker.sv
verif/best_fit_record_allocator_top_tb.sv
